[rtl/core/mer_pkg.sv]
// Shared types, sizes and saturating arithmetic for the marker effect residual update.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  localparam int ELEMENTS   = 1024;
  localparam int COMPONENTS = 4;

  localparam int IDX_W    = 10;
  localparam int WORD_W   = 32;
  localparam int CLASS_W  = 3;
  localparam int DIFF_W   = WORD_W + 1;
  localparam int PROD_W   = DIFF_W + WORD_W;
  localparam int ROUND_SH = 24;
  localparam int TERM_W   = PROD_W - ROUND_SH;
  localparam int SUM_W    = TERM_W + 2;

  // Store numbering: residual, genetic, then one per mixture component
  localparam int NUM_MEM   = 2 + COMPONENTS;
  localparam int MEM_RES   = 0;
  localparam int MEM_GEN   = 1;
  localparam int MEM_COMP0 = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [TERM_W-1:0] term_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               in_range;
    logic               skip;
    logic               last;
    logic [CLASS_W-1:0] oc;
    logic [CLASS_W-1:0] nc;
    logic [IDX_W-1:0]   idx;
  } ctl_t;

  // Add or subtract a rounded term and clamp to the signed word range
  function automatic word_t sat_add(word_t v, term_t t, logic neg);
    logic signed [SUM_W-1:0] s;
    word_t                   r;
    s = neg ? (SUM_W'(v) - SUM_W'(t)) : (SUM_W'(v) + SUM_W'(t));
    if (s[SUM_W-1:WORD_W-1] == '0 || s[SUM_W-1:WORD_W-1] == '1) begin
      r = s[WORD_W-1:0];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/mer_bank.sv]
// One per-sample store of the update block: single write port, one registered read port.
// Depends on mer_pkg for the depth and word type.
`timescale 1ns / 1ps
`default_nettype none

module mer_bank import mer_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_addr_i,
  output word_t                 rd_data_o,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] wr_addr_i,
  input  wire word_t            wr_data_i
);

  word_t mem_q [ELEMENTS];
  word_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read-first: a same-address write in this cycle is not seen here
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

[rtl/core/mer_term.sv]
// Two-stage fixed-point product: registered multiply, then round-half-up to Q17.24.
// Depends on mer_pkg for operand and term widths.
`timescale 1ns / 1ps
`default_nettype none

module mer_term import mer_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [DIFF_W-1:0] a_i,
  input  wire word_t                    b_i,
  output term_t                         term_o
);

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (ROUND_SH - 1);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] rnd;
  term_t                    term_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign rnd = prod_q + HALF;

  // Arithmetic shift gives the floor of the quotient
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q <= TERM_W'(rnd >>> ROUND_SH);
    end
  end

  assign term_o = term_q;

endmodule

`default_nettype wire

[rtl/core/marker_effect_residual_update.sv]
// Top level of the marker effect residual update: stream ports, pipeline control, stores.
// Depends on mer_pkg, mer_bank and mer_term.
`timescale 1ns / 1ps
`default_nettype none

// Takes one sample element per cycle and applies a marker effect change to the residual,
// genetic value and mixture component stores of that element; each transfer gives one
// result with the element's values after the step. From input transfer to output valid an
// item passes four register stages: a memory read stage, a multiply stage, a rounding stage
// and the output register, which takes the saturating add whose result is written back at
// the same edge, with forwarding so that back-to-back items on the same element see each
// other's results. Throughput is one item per cycle; the only stall comes from the output
// side. After reset, a clearing pass zeroes the genetic and component stores, during which
// s_axis_tready stays low. The residual store is not cleared: load every element before
// updating it. mixture_enable is written through cfg_we_i / cfg_wdata_i and resets to 1;
// the user must write it only while the block is idle, which the block does not enforce.
module marker_effect_residual_update import mer_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_wdata_i,     // mixture_enable
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // element_index[9:0], col_value[41:10], prev_effect[73:42], next_effect[105:74],
  // prev_class[108:106], next_class[111:109], load_value[143:112]
  input  wire logic [143:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,    // operation
  input  wire logic         s_axis_tlast,    // last
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // residual_out[31:0], genetic_out[63:32], old_component_out[95:64],
  // new_component_out[127:96]
  output logic [127:0]      m_axis_tdata,
  output logic              m_axis_tuser,    // skipped
  output logic              m_axis_tlast     // last_out
);

  localparam int COL_LO = IDX_W;
  localparam int OV_LO  = COL_LO + WORD_W;
  localparam int NV_LO  = OV_LO + WORD_W;
  localparam int OC_LO  = NV_LO + WORD_W;
  localparam int NC_LO  = OC_LO + CLASS_W;
  localparam int LD_LO  = NC_LO + CLASS_W;

  // ---------------------------------------------------------------- control
  logic cfg_mix_q;
  logic clr_busy_q;
  logic [IDX_W-1:0] clr_cnt_q;
  logic adv;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mix_q <= 1'b1;
    end else if (cfg_we_i) begin
      cfg_mix_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == IDX_W'(ELEMENTS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // Whole pipeline moves together; it holds only while the output waits
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !clr_busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- entry decode
  logic [IDX_W-1:0]   in_idx;
  word_t              in_col;
  word_t              in_ov;
  word_t              in_nv;
  word_t              in_ld;
  logic [CLASS_W-1:0] in_oc;
  logic [CLASS_W-1:0] in_nc;
  ctl_t               in_ctl;

  assign in_idx = s_axis_tdata[IDX_W-1:0];
  assign in_col = s_axis_tdata[COL_LO +: WORD_W];
  assign in_ov  = s_axis_tdata[OV_LO +: WORD_W];
  assign in_nv  = s_axis_tdata[NV_LO +: WORD_W];
  assign in_oc  = s_axis_tdata[OC_LO +: CLASS_W];
  assign in_nc  = s_axis_tdata[NC_LO +: CLASS_W];
  assign in_ld  = s_axis_tdata[LD_LO +: WORD_W];

  always_comb begin
    in_ctl          = '0;
    in_ctl.op       = op_e'(s_axis_tuser);
    in_ctl.last     = s_axis_tlast;
    in_ctl.idx      = in_idx;
    in_ctl.in_range = {1'b0, in_idx} < (IDX_W + 1)'(ELEMENTS);
    // Classes beyond the component count, or with mixture off, mean none
    if (cfg_mix_q && in_oc != '0 && in_oc <= CLASS_W'(COMPONENTS)) begin
      in_ctl.oc = in_oc;
    end
    if (cfg_mix_q && in_nc != '0 && in_nc <= CLASS_W'(COMPONENTS)) begin
      in_ctl.nc = in_nc;
    end
    in_ctl.skip = !in_ctl.in_range ||
                  (in_ctl.op == OP_UPDATE && in_ov == in_nv && in_ctl.oc == in_ctl.nc);
  end

  // ---------------------------------------------------------------- stores
  word_t              rd_data [NUM_MEM];
  logic [NUM_MEM-1:0] bank_we;
  logic [IDX_W-1:0]   bank_waddr;
  word_t              bank_wdata [NUM_MEM];
  logic [NUM_MEM-1:0] fire;
  word_t              f [NUM_MEM];

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  ctl_t s1_ctl_q, s2_ctl_q, s3_ctl_q;

  assign bank_waddr = clr_busy_q ? clr_cnt_q : s3_ctl_q.idx;

  for (genvar m = 0; m < NUM_MEM; m++) begin : g_bank
    // The residual store has no reset value and is left out of the clearing pass
    assign bank_we[m]    = clr_busy_q ? (m != MEM_RES) : fire[m];
    assign bank_wdata[m] = clr_busy_q ? '0 : f[m];

    mer_bank u_bank (
      .clk_i    (clk_i),
      .rd_en_i  (adv),
      .rd_addr_i(in_idx),
      .rd_data_o(rd_data[m]),
      .we_i     (bank_we[m]),
      .wr_addr_i(bank_waddr),
      .wr_data_i(bank_wdata[m])
    );
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [DIFF_W-1:0] s1_diff_q;
  word_t                    s1_col_q;
  word_t                    s1_ov_q;
  word_t                    s1_nv_q;
  word_t                    s1_ld_q;
  logic [NUM_MEM-1:0]       s1_hit_q;
  word_t                    s1_fwd_q [NUM_MEM];
  word_t                    v1 [NUM_MEM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ctl_q  <= in_ctl;
      s1_diff_q <= DIFF_W'(in_ov) - DIFF_W'(in_nv);
      s1_col_q  <= in_col;
      s1_ov_q   <= in_ov;
      s1_nv_q   <= in_nv;
      s1_ld_q   <= in_ld;
      // Catch the write-back that the read-first memory misses this cycle
      for (int m = 0; m < NUM_MEM; m++) begin
        s1_hit_q[m] <= fire[m] && (s3_ctl_q.idx == in_idx);
        s1_fwd_q[m] <= f[m];
      end
    end
  end

  always_comb begin
    for (int m = 0; m < NUM_MEM; m++) begin
      v1[m] = s1_hit_q[m] ? s1_fwd_q[m] : rd_data[m];
    end
  end

  // ---------------------------------------------------------------- stages 2 and 3
  term_t t_diff;
  term_t t_old;
  term_t t_new;

  mer_term u_term_diff (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (s1_diff_q),
    .b_i   (s1_col_q),
    .term_o(t_diff)
  );

  mer_term u_term_old (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (DIFF_W'(s1_ov_q)),
    .b_i   (s1_col_q),
    .term_o(t_old)
  );

  mer_term u_term_new (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (DIFF_W'(s1_nv_q)),
    .b_i   (s1_col_q),
    .term_o(t_new)
  );

  word_t s2_ld_q;
  word_t s3_ld_q;
  word_t v2_q [NUM_MEM];
  word_t v3_q [NUM_MEM];

  // Values travel with the item and pick up every write-back that passes them
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ctl_q <= s1_ctl_q;
      s2_ld_q  <= s1_ld_q;
      s3_ctl_q <= s2_ctl_q;
      s3_ld_q  <= s2_ld_q;
      for (int m = 0; m < NUM_MEM; m++) begin
        v2_q[m] <= (fire[m] && s3_ctl_q.idx == s1_ctl_q.idx) ? f[m] : v1[m];
        v3_q[m] <= (fire[m] && s3_ctl_q.idx == s2_ctl_q.idx) ? f[m] : v2_q[m];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3 update
  logic                  upd;
  logic                  is_load;
  logic [NUM_MEM-1:0]    pipe_we;
  logic [COMPONENTS-1:0] is_old;
  logic [COMPONENTS-1:0] is_new;

  assign upd     = s3_valid_q && s3_ctl_q.in_range && !s3_ctl_q.skip;
  assign is_load = (s3_ctl_q.op == OP_LOAD);

  always_comb begin
    pipe_we = '0;
    for (int m = 0; m < NUM_MEM; m++) begin
      f[m] = v3_q[m];
    end

    pipe_we[MEM_RES] = upd;
    if (is_load) begin
      f[MEM_RES] = s3_ld_q;
    end else if (upd) begin
      f[MEM_RES] = sat_add(v3_q[MEM_RES], t_diff, 1'b0);
    end

    pipe_we[MEM_GEN] = upd && !is_load;
    if (upd && !is_load) begin
      f[MEM_GEN] = sat_add(v3_q[MEM_GEN], t_diff, 1'b1);
    end

    for (int b = 0; b < COMPONENTS; b++) begin
      is_old[b] = (s3_ctl_q.oc == CLASS_W'(b + 1));
      is_new[b] = (s3_ctl_q.nc == CLASS_W'(b + 1));
      pipe_we[MEM_COMP0 + b] = upd && !is_load && (is_old[b] || is_new[b]);
      if (upd && !is_load) begin
        if (is_old[b] && is_new[b]) begin
          f[MEM_COMP0 + b] = sat_add(v3_q[MEM_COMP0 + b], t_diff, 1'b1);
        end else if (is_old[b]) begin
          f[MEM_COMP0 + b] = sat_add(v3_q[MEM_COMP0 + b], t_old, 1'b1);
        end else if (is_new[b]) begin
          f[MEM_COMP0 + b] = sat_add(v3_q[MEM_COMP0 + b], t_new, 1'b0);
        end
      end
    end
  end

  assign fire = adv ? pipe_we : '0;

  // ---------------------------------------------------------------- output register
  word_t old_sel;
  word_t new_sel;

  always_comb begin
    old_sel = '0;
    new_sel = '0;
    for (int b = 0; b < COMPONENTS; b++) begin
      if (is_old[b]) begin
        old_sel = f[MEM_COMP0 + b];
      end
      if (is_new[b]) begin
        new_sel = f[MEM_COMP0 + b];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s3_ctl_q.in_range) begin
        m_axis_tdata <= {new_sel, old_sel, f[MEM_GEN], f[MEM_RES]};
      end else begin
        m_axis_tdata <= '0;
      end
      m_axis_tuser <= s3_ctl_q.skip;
      m_axis_tlast <= s3_ctl_q.last;
    end
  end

  // ---------------------------------------------------------------- checks
  a_clear_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !(s1_valid_q || s2_valid_q || s3_valid_q || m_axis_tvalid))
    else $error("item in flight during clearing pass");

  a_comp_two_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pipe_we[NUM_MEM-1:MEM_COMP0]) <= 2)
    else $error("more than two component stores written by one item");

  a_skip_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && s3_ctl_q.skip) |-> (pipe_we == '0))
    else $error("skipped item writes a store");

endmodule

`default_nettype wire
